>>> hw/rtl/line_sensor_calibrate_normalize_unit_defines.svh
// Assertion macros for the line sensor calibrate/normalize block.
// Included by the top level; no other dependencies.
`ifndef LINE_SENSOR_CALIBRATE_NORMALIZE_UNIT_DEFINES_SVH
`define LINE_SENSOR_CALIBRATE_NORMALIZE_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
// Check a property at every rising clock edge outside reset.
`define LSCN_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Check that a condition leads to a consequence in the next cycle.
`define LSCN_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define LSCN_ASSERT(lbl, clk, rstn, prop, msg)
`define LSCN_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

>>> hw/rtl/lscn_pkg.sv
// Shared types and constants of the line sensor calibrate/normalize block.
// No dependencies; imported by every module of the block.
package lscn_pkg;

  localparam int CHAN_W     = 3;
  localparam int SAMPLE_W   = 10;
  localparam int LEVEL_W    = 7;
  localparam int FULL_SCALE = 100;
  localparam int MIN_RESET  = 500;
  localparam logic [LEVEL_W-1:0] THRESH_RESET = 7'd60;

  typedef enum logic {
    KIND_CAL  = 1'b0,
    KIND_NORM = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    STEER_FWD   = 2'd0,
    STEER_LEFT  = 2'd1,
    STEER_RIGHT = 2'd2
  } steer_e;

  typedef struct packed {
    kind_e               kind;
    logic [CHAN_W-1:0]   channel;
    logic [SAMPLE_W-1:0] sample;
  } lscn_in_t;

  typedef struct packed {
    logic [CHAN_W-1:0]   out_channel;
    logic [LEVEL_W-1:0]  level;
    logic                uncalibrated;
    logic [SAMPLE_W-1:0] low_mark;
    logic [SAMPLE_W-1:0] high_mark;
    steer_e              steer;
  } lscn_out_t;

  // Status of the shared subtractor: a >= b and a > b.
  typedef struct packed {
    logic ge;
    logic gt;
  } lscn_flags_t;

endpackage

>>> hw/rtl/lscn_sub.sv
// Shared subtract/compare unit of the calibrate/normalize sequencer.
// Depends on lscn_pkg for the flag struct.
module lscn_sub import lscn_pkg::*; #(
  parameter int W = 17
) (
  input  logic [W-1:0] a_i,
  input  logic [W-1:0] b_i,
  output logic [W-1:0] diff_o,
  output lscn_flags_t  flags_o
);

  logic [W:0] sum;

  // Carry out of a + ~b + 1 is set when no borrow occurs.
  assign sum          = {1'b0, a_i} + {1'b0, ~b_i} + (W+1)'(1);
  assign diff_o       = sum[W-1:0];
  assign flags_o.ge   = sum[W];
  assign flags_o.gt   = sum[W] && (sum[W-1:0] != '0);

endmodule

>>> hw/rtl/line_sensor_calibrate_normalize_unit.sv
// Top level of the line sensor calibrate/normalize block.
// Depends on lscn_pkg, lscn_sub and the assertion macro header.
`include "line_sensor_calibrate_normalize_unit_defines.svh"

// One sample per transaction. A calibrate transaction widens the channel's
// stored min/max. A normalize transaction keeps as the channel's level
// (sample-min)*100/(max-min), truncated and clamped to 0..100; the level is
// settled without division for an uncalibrated channel, a sample at or below
// min, or one at or above max. One shared subtractor does the three compares
// and then the 7 restoring division steps, one per cycle. The input stalls
// while a transaction is in work; a finished result waits in an output
// register, so a new sample is taken while the previous result is still
// stalled. Every result also carries a steering verdict from all kept levels
// against the configured threshold. No clearing pass is needed after reset.
module line_sensor_calibrate_normalize_unit import lscn_pkg::*; #(
  parameter int CHANNELS    = 8,
  parameter int SAMPLE_BITS = 10
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  lscn_in_t           in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output lscn_out_t          out_data_o,
  input  logic               cfg_we_i,
  input  logic [LEVEL_W-1:0] cfg_wdata_i
);

  localparam int SW      = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
  localparam int NW      = SW + LEVEL_W;
  localparam int CW      = $clog2(CHANNELS);
  localparam int XW      = ((CW > CHAN_W) ? CW : CHAN_W) + 1;
  localparam int HALF    = CHANNELS / 2;
  localparam int SMAX    = (2 ** SW) - 1;
  localparam int MIN_RST = (MIN_RESET > SMAX) ? SMAX : MIN_RESET;
  localparam int CNT_W   = $clog2(LEVEL_W);

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_OFFS  = 8'b0000_0010,
    ST_TOP   = 8'b0000_0100,
    ST_SPAN  = 8'b0000_1000,
    ST_SCALE = 8'b0001_0000,
    ST_DIV   = 8'b0010_0000,
    ST_WRITE = 8'b0100_0000,
    ST_FIN   = 8'b1000_0000
  } state_e;

  state_e             state_q, state_d;
  kind_e              kind_q, kind_d;
  logic [CHAN_W-1:0]  chan_q, chan_d;
  logic [SW-1:0]      samp_q, samp_d;
  logic [SW-1:0]      off_q, off_d;
  logic [SW-1:0]      span_q, span_d;
  logic               s_gt_mn_q, s_gt_mn_d;
  logic               s_ge_mx_q, s_ge_mx_d;
  logic               mx_gt_mn_q, mx_gt_mn_d;
  logic [NW-1:0]      rem_q, rem_d;
  logic [NW-1:0]      den_q, den_d;
  logic [LEVEL_W-1:0] quo_q, quo_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [LEVEL_W-1:0] level_q, level_d;
  logic [LEVEL_W-1:0] thr_q, thr_d;

  logic [SW-1:0]      min_q [CHANNELS];
  logic [SW-1:0]      min_d [CHANNELS];
  logic [SW-1:0]      max_q [CHANNELS];
  logic [SW-1:0]      max_d [CHANNELS];
  logic [LEVEL_W-1:0] lvl_q [CHANNELS];
  logic [LEVEL_W-1:0] lvl_d [CHANNELS];

  logic               out_valid_q, out_valid_d;
  lscn_out_t          out_q, out_d;

  logic [XW-1:0]      ch_wide;
  logic [CW-1:0]      idx;
  logic               ch_ok;
  logic [SW-1:0]      mn, mx;
  logic [NW-1:0]      alu_a, alu_b, alu_diff;
  lscn_flags_t        alu_flags;
  logic [NW-1:0]      scaled;
  logic               left_hit, right_hit;
  steer_e             verdict;

  assign ch_wide = XW'(chan_q);
  assign idx     = ch_wide[CW-1:0];
  assign ch_ok   = ch_wide < XW'(CHANNELS);
  assign mn      = min_q[idx];
  assign mx      = max_q[idx];
  assign scaled  = NW'(off_q) * NW'(FULL_SCALE);

  always_comb begin
    unique case (state_q)
      ST_OFFS: begin
        alu_a = NW'(samp_q);
        alu_b = NW'(mn);
      end
      ST_TOP: begin
        alu_a = NW'(samp_q);
        alu_b = NW'(mx);
      end
      ST_SPAN: begin
        alu_a = NW'(mx);
        alu_b = NW'(mn);
      end
      ST_DIV: begin
        alu_a = rem_q;
        alu_b = den_q;
      end
      default: begin
        alu_a = '0;
        alu_b = '0;
      end
    endcase
  end

  lscn_sub #(
    .W (NW)
  ) u_sub (
    .a_i     (alu_a),
    .b_i     (alu_b),
    .diff_o  (alu_diff),
    .flags_o (alu_flags)
  );

  always_comb begin
    left_hit  = 1'b0;
    right_hit = 1'b0;
    for (int c = 0; c < CHANNELS; c++) begin
      if (c < HALF) begin
        left_hit = left_hit | (lvl_q[c] < thr_q);
      end else begin
        right_hit = right_hit | (lvl_q[c] < thr_q);
      end
    end
    priority if (left_hit) begin
      verdict = STEER_LEFT;
    end else if (right_hit) begin
      verdict = STEER_RIGHT;
    end else begin
      verdict = STEER_FWD;
    end
  end

  always_comb begin
    state_d     = state_q;
    kind_d      = kind_q;
    chan_d      = chan_q;
    samp_d      = samp_q;
    off_d       = off_q;
    span_d      = span_q;
    s_gt_mn_d   = s_gt_mn_q;
    s_ge_mx_d   = s_ge_mx_q;
    mx_gt_mn_d  = mx_gt_mn_q;
    rem_d       = rem_q;
    den_d       = den_q;
    quo_d       = quo_q;
    cnt_d       = cnt_q;
    level_d     = level_q;
    thr_d       = cfg_we_i ? cfg_wdata_i : thr_q;
    min_d       = min_q;
    max_d       = max_q;
    lvl_d       = lvl_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          kind_d  = in_data_i.kind;
          chan_d  = in_data_i.channel;
          samp_d  = in_data_i.sample[SW-1:0];
          level_d = '0;
          state_d = ST_OFFS;
        end
      end
      ST_OFFS: begin
        off_d     = alu_diff[SW-1:0];
        s_gt_mn_d = alu_flags.gt;
        state_d   = ST_TOP;
      end
      ST_TOP: begin
        s_ge_mx_d = alu_flags.ge;
        priority if (!ch_ok) begin
          state_d = ST_FIN;
        end else if (kind_q == KIND_CAL) begin
          if (alu_flags.ge) begin
            max_d[idx] = samp_q;
          end
          if (!s_gt_mn_q) begin
            min_d[idx] = samp_q;
          end
          state_d = ST_FIN;
        end else begin
          state_d = ST_SPAN;
        end
      end
      ST_SPAN: begin
        span_d     = alu_diff[SW-1:0];
        mx_gt_mn_d = alu_flags.gt;
        state_d    = ST_SCALE;
      end
      ST_SCALE: begin
        rem_d = scaled;
        den_d = NW'(span_q) << (LEVEL_W - 1);
        quo_d = '0;
        cnt_d = CNT_W'(LEVEL_W - 1);
        // Settle the level without division where the span or the offset
        // leaves nothing to divide, or the sample sits at or above max.
        priority if (!mx_gt_mn_q || !s_gt_mn_q) begin
          level_d = '0;
          state_d = ST_WRITE;
        end else if (s_ge_mx_q) begin
          level_d = LEVEL_W'(FULL_SCALE);
          state_d = ST_WRITE;
        end else begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (alu_flags.ge) begin
          rem_d = alu_diff;
        end
        quo_d = {quo_q[LEVEL_W-2:0], alu_flags.ge};
        den_d = den_q >> 1;
        cnt_d = cnt_q - CNT_W'(1);
        if (cnt_q == '0) begin
          level_d = {quo_q[LEVEL_W-2:0], alu_flags.ge};
          state_d = ST_WRITE;
        end
      end
      ST_WRITE: begin
        lvl_d[idx] = level_q;
        state_d    = ST_FIN;
      end
      ST_FIN: begin
        // Hold here until the output register is free.
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d          = 1'b1;
          out_d.out_channel    = chan_q;
          out_d.level          = level_q;
          out_d.uncalibrated   = ch_ok ? (mx <= mn) : 1'b1;
          out_d.low_mark       = ch_ok ? SAMPLE_W'(mn) : '0;
          out_d.high_mark      = ch_ok ? SAMPLE_W'(mx) : '0;
          out_d.steer          = verdict;
          state_d              = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      thr_q       <= THRESH_RESET;
      for (int c = 0; c < CHANNELS; c++) begin
        min_q[c] <= SW'(MIN_RST);
        max_q[c] <= '0;
        lvl_q[c] <= '0;
      end
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      thr_q       <= thr_d;
      min_q       <= min_d;
      max_q       <= max_d;
      lvl_q       <= lvl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q     <= kind_d;
    chan_q     <= chan_d;
    samp_q     <= samp_d;
    off_q      <= off_d;
    span_q     <= span_d;
    s_gt_mn_q  <= s_gt_mn_d;
    s_ge_mx_q  <= s_ge_mx_d;
    mx_gt_mn_q <= mx_gt_mn_d;
    rem_q      <= rem_d;
    den_q      <= den_d;
    quo_q      <= quo_d;
    cnt_q      <= cnt_d;
    level_q    <= level_d;
    out_q      <= out_d;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `LSCN_ASSERT(a_level_range, clk_i, rst_ni, !out_valid_o || (out_data_o.level <= LEVEL_W'(FULL_SCALE)), "level above full scale")
  `LSCN_ASSERT(a_uncal_zero, clk_i, rst_ni, !(out_valid_o && out_data_o.uncalibrated) || (out_data_o.level == '0), "uncalibrated result with nonzero level")
  `LSCN_ASSERT_NEXT(a_div_end, clk_i, rst_ni, (state_q == ST_DIV) && (cnt_q == '0), state_q == ST_WRITE, "division did not finish after its last step")
  `LSCN_ASSERT_NEXT(a_busy, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o, "input not stalled after a transaction")

endmodule

>>> dv/line_sensor_calibrate_normalize_unit_tb.sv
// Self-checking testbench for line_sensor_calibrate_normalize_unit: sample transactions in,
// per-channel readings out, each checked against an in-bench predictor. Depends on lscn_pkg.
`timescale 1ns / 100ps

module line_sensor_calibrate_normalize_unit_tb;
  import lscn_pkg::*;

  localparam int NUM_CH       = 1 << CHAN_W;
  localparam int DRAIN_CYCLES = 16;
  localparam int HOLD_MARK    = 150;
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASE_ITEMS  = 75;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  lscn_in_t           in_data_i   = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  lscn_out_t          out_data_o;
  logic               cfg_we_i    = 1'b0;
  logic [LEVEL_W-1:0] cfg_wdata_i = '0;

  line_sensor_calibrate_normalize_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  lscn_in_t    pending_samples[$];
  lscn_out_t   predicted_readings[$];
  int unsigned low_store[NUM_CH];
  int unsigned high_store[NUM_CH];
  int unsigned kept_level[NUM_CH];
  int unsigned threshold_now;
  int unsigned mismatches    = 0;
  int unsigned samples_taken = 0;
  logic        in_fire       = 1'b0;
  logic        quiet         = 1'b0;
  int          send_gap      = 0;
  int          stall_left    = 0;
  int          hold_left     = 0;
  logic        hold_done     = 1'b0;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Apply one sample to the channel state and return the reading it produces.
  function automatic lscn_out_t calibrate_normalize(input lscn_in_t item);
    lscn_out_t   res;
    int unsigned ch;
    int unsigned s;
    int unsigned mn;
    int unsigned mx;
    int unsigned q;
    ch  = 32'(item.channel);
    s   = 32'(item.sample);
    res = '0;
    res.out_channel = item.channel;
    if (item.kind == KIND_CAL) begin
      if (s >= high_store[ch]) high_store[ch] = s;
      if (s <= low_store[ch]) low_store[ch] = s;
    end else begin
      mn = low_store[ch];
      mx = high_store[ch];
      q  = 0;
      if (mx > mn && s > mn) begin
        q = ((s - mn) * FULL_SCALE) / (mx - mn);
        if (q > FULL_SCALE) q = FULL_SCALE;
      end
      kept_level[ch] = q;
      res.level = q[LEVEL_W-1:0];
    end
    res.low_mark     = low_store[ch][SAMPLE_W-1:0];
    res.high_mark    = high_store[ch][SAMPLE_W-1:0];
    res.uncalibrated = (high_store[ch] <= low_store[ch]);
    res.steer        = STEER_FWD;
    // Walk down so the lowest channel below threshold decides the side.
    for (int c = NUM_CH - 1; c >= 0; c--) begin
      if (kept_level[c] < threshold_now) begin
        if (c < NUM_CH / 2) res.steer = STEER_LEFT;
        else res.steer = STEER_RIGHT;
      end
    end
    return res;
  endfunction

  task automatic check_field(input string label, input int unsigned want_v,
                             input int unsigned got_v);
    if (want_v != got_v) begin
      $display("%0t: %s expected %0d, actual %0d", $time, label, want_v, got_v);
      mismatches++;
    end
  endtask

  // Monitor: predict on every accepted sample, check every accepted reading.
  always @(posedge clk_i) begin : monitor
    logic      fire;
    lscn_out_t want;
    fire = rst_ni && in_valid_i && !in_stall_o;
    in_fire <= fire;
    if (fire) begin
      predicted_readings.push_back(calibrate_normalize(in_data_i));
      samples_taken++;
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (predicted_readings.size() == 0) begin
        $display("%0t: unexpected reading, expected none, actual %p", $time, out_data_o);
        mismatches++;
      end else begin
        want = predicted_readings.pop_front();
        check_field("out_channel", 32'(want.out_channel), 32'(out_data_o.out_channel));
        check_field("level", 32'(want.level), 32'(out_data_o.level));
        check_field("uncalibrated", 32'(want.uncalibrated), 32'(out_data_o.uncalibrated));
        check_field("low_mark", 32'(want.low_mark), 32'(out_data_o.low_mark));
        check_field("high_mark", 32'(want.high_mark), 32'(out_data_o.high_mark));
        check_field("steer", 32'(want.steer), 32'(out_data_o.steer));
      end
    end
  end

  // Driver: hold a stalled transaction, otherwise advance after an optional gap.
  always @(negedge clk_i) begin : driver
    logic     next_valid;
    lscn_in_t next_data;
    next_valid = in_valid_i;
    next_data  = in_data_i;
    if (!in_valid_i || in_fire) begin
      next_valid = 1'b0;
      if (in_fire && !quiet && $urandom_range(0, 4) == 0) send_gap = $urandom_range(1, 11);
      if (send_gap > 0) begin
        send_gap--;
      end else if (pending_samples.size() != 0) begin
        next_data  = pending_samples.pop_front();
        next_valid = 1'b1;
      end
    end
    in_valid_i <= next_valid;
    in_data_i  <= next_data;
  end

  // Receiver: random stall bursts plus one long hold-off to back up the block.
  always @(negedge clk_i) begin : receiver
    logic next_stall;
    next_stall = 1'b0;
    if (!hold_done && samples_taken >= HOLD_MARK) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      next_stall = 1'b1;
    end else if (!quiet) begin
      if (stall_left > 0) begin
        stall_left--;
        next_stall = 1'b1;
      end else if ($urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 11) - 1;
        next_stall = 1'b1;
      end
    end
    out_stall_i <= next_stall;
  end

  task automatic queue_item(input kind_e k, input int unsigned ch, input int unsigned s);
    lscn_in_t item;
    item.kind    = k;
    item.channel = ch[CHAN_W-1:0];
    item.sample  = s[SAMPLE_W-1:0];
    pending_samples.push_back(item);
  endtask

  task automatic queue_random(input int count);
    lscn_in_t item;
    repeat (count) begin
      item.kind    = ($urandom_range(0, 9) < 4) ? KIND_CAL : KIND_NORM;
      item.channel = CHAN_W'($urandom_range(0, NUM_CH - 1));
      case ($urandom_range(0, 9))
        0: item.sample = '0;
        1: item.sample = '1;
        default: begin
          // Keep most calibration inside mid-range so clamping stays reachable.
          if (item.kind == KIND_CAL && $urandom_range(0, 5) != 0)
            item.sample = SAMPLE_W'($urandom_range(200, 800));
          else
            item.sample = SAMPLE_W'($urandom_range(0, 1023));
        end
      endcase
      pending_samples.push_back(item);
    end
  endtask

  // Wait until every queued transaction has come back, then let the block settle.
  task automatic settle();
    while (pending_samples.size() != 0 || in_valid_i || predicted_readings.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_threshold(input logic [LEVEL_W-1:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    threshold_now = 32'(value);
  endtask

  initial begin : stimulus
    logic [LEVEL_W-1:0] thresholds[6];
    threshold_now = 32'(THRESH_RESET);
    for (int c = 0; c < NUM_CH; c++) begin
      low_store[c]  = MIN_RESET;
      high_store[c] = 0;
      kept_level[c] = 0;
    end
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Uncalibrated channel, then a full-scale range on channel 0.
    queue_item(KIND_NORM, 0, 300);
    queue_item(KIND_CAL, 0, 0);
    queue_item(KIND_CAL, 0, 1023);
    queue_item(KIND_NORM, 0, 0);
    queue_item(KIND_NORM, 0, 511);
    queue_item(KIND_NORM, 0, 1023);
    // Sample equal to min, then clamping below min and above max.
    queue_item(KIND_CAL, 1, 500);
    queue_item(KIND_CAL, 1, 200);
    queue_item(KIND_CAL, 1, 800);
    queue_item(KIND_NORM, 1, 100);
    queue_item(KIND_NORM, 1, 500);
    queue_item(KIND_NORM, 1, 900);
    // Raise every level to full scale for forward, then drop one per side.
    for (int c = 2; c < NUM_CH; c++) queue_item(KIND_CAL, c, 1023);
    for (int c = 2; c < NUM_CH; c++) queue_item(KIND_NORM, c, 1023);
    queue_item(KIND_NORM, 5, 0);
    queue_item(KIND_NORM, 2, 0);
    settle();

    thresholds[0] = '0;
    thresholds[1] = '1;
    thresholds[2] = 7'd100;
    thresholds[3] = LEVEL_W'($urandom_range(1, 99));
    thresholds[4] = 7'd1;
    thresholds[5] = 7'd101;
    for (int p = 0; p < 6; p++) begin
      write_threshold(thresholds[p]);
      if (p == 5) quiet = 1'b1;
      queue_random(PHASE_ITEMS);
      settle();
    end

    if (mismatches == 0) begin
      $display("line_sensor_calibrate_normalize_unit: match");
    end else begin
      $display("line_sensor_calibrate_normalize_unit: mismatch");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("line_sensor_calibrate_normalize_unit: mismatch");
    $finish;
  end

endmodule
